>>> hw/rtl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int NUM_PIXELS_DEF = 16;
  localparam int FADE_STEPS_DEF = 64;

  localparam int FUNC_W = 2;
  localparam int PIX_W  = 6;
  localparam int CH_W   = 8;
  localparam int COL_W  = 3 * CH_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET   = 2'd0,
    FN_START = 2'd1,
    FN_TICK  = 2'd2
  } func_t;

  // Read request as it leaves the memories: aligned with the registered read data
  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] idx;
    logic             tgt_ok;
    logic             shw_ok;
  } rd_t;

  // Write-back of one blended pixel into the shown-color memory
  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] idx;
  } wb_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } res_t;

endpackage

>>> hw/rtl/lsc_if.sv
`timescale 1ns / 1ps

interface lsc_in_if import lsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PIX_W-1:0]  pixel;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;

  modport source (output valid, func, pixel, red, green, blue, input ready);
  modport sink   (input valid, func, pixel, red, green, blue, output ready);
endinterface

interface lsc_out_if import lsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             last;

  modport source (output valid, pixel, red, green, blue, last, input ready);
  modport sink   (input valid, pixel, red, green, blue, last, output ready);
endinterface

>>> hw/rtl/lsc_ram.sv
`timescale 1ns / 1ps

module lsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/lsc_ctrl.sv
`timescale 1ns / 1ps

module lsc_ctrl import lsc_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF,
  parameter int FADE_STEPS = FADE_STEPS_DEF,
  localparam int AW  = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1,
  localparam int KB  = $clog2(FADE_STEPS + 1),
  localparam int FCW = KB + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              en,
  input  logic              pipe_busy,
  input  wb_t               wb,
  output logic              tgt_we,
  output logic [AW-1:0]     rd_addr,
  output rd_t               rd,
  output logic [KB-1:0]     k
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t                 state_r;
  logic [AW-1:0]          rd_idx_r;
  rd_t                    rd_r;
  logic [KB-1:0]          k_r;
  logic signed [FCW-1:0]  fade_r;
  logic [NUM_PIXELS-1:0]  tgt_ok_r;
  logic [NUM_PIXELS-1:0]  shw_ok_r;
  logic                   in_acc;
  logic                   pix_in_range;

  assign in_ready     = (state_r == ST_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign pix_in_range = ({1'b0, in_pixel} < (PIX_W+1)'(NUM_PIXELS));
  assign tgt_we       = in_acc && (in_func == FN_SET) && pix_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
      rd_r     <= '0;
      k_r      <= '0;
      fade_r   <= '1;
      tgt_ok_r <= '0;
      shw_ok_r <= '0;
    end else begin
      if (tgt_we) begin
        tgt_ok_r[in_pixel[AW-1:0]] <= 1'b1;
      end
      if (wb.vld) begin
        shw_ok_r[wb.idx[AW-1:0]] <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (en) begin
            rd_r.vld <= 1'b0;
          end
          if (in_acc) begin
            unique case (in_func)
              FN_START: begin
                fade_r <= FCW'(FADE_STEPS);
              end
              FN_TICK: begin
                // idle tick when the counter has gone negative
                if (!fade_r[FCW-1]) begin
                  k_r      <= fade_r[KB-1:0];
                  fade_r   <= fade_r - FCW'(1);
                  rd_idx_r <= '0;
                  state_r  <= ST_RUN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (en) begin
            rd_r.vld    <= 1'b1;
            rd_r.idx    <= PIX_W'(rd_idx_r);
            rd_r.tgt_ok <= tgt_ok_r[rd_idx_r];
            rd_r.shw_ok <= shw_ok_r[rd_idx_r];
            rd_idx_r    <= rd_idx_r + AW'(1);
            if (rd_idx_r == AW'(NUM_PIXELS - 1)) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (en) begin
            rd_r.vld <= 1'b0;
          end
          // release once the last write-back has gone to memory
          if (!rd_r.vld && !pipe_busy) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign rd_addr = rd_idx_r;
  assign rd      = rd_r;
  assign k       = k_r;

endmodule

>>> hw/rtl/lsc_blend.sv
`timescale 1ns / 1ps

module lsc_blend import lsc_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF,
  parameter int FADE_STEPS = FADE_STEPS_DEF,
  localparam int KB = $clog2(FADE_STEPS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rd_t              rd,
  input  logic [COL_W-1:0] tgt_rdata,
  input  logic [COL_W-1:0] shw_rdata,
  input  logic [KB-1:0]    k,
  output logic             en,
  output logic             pipe_busy,
  output wb_t              wb,
  output logic [COL_W-1:0] wb_data,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             res
);

  localparam int NUMW    = CH_W + KB;
  localparam int PRODW   = 2 * NUMW + 1;
  localparam int RECIP_I = (1 << NUMW) / FADE_STEPS;
  localparam logic [NUMW:0] RECIP = (NUMW+1)'(RECIP_I);

  logic [COL_W-1:0] t_col;
  logic [COL_W-1:0] s_col;
  logic [KB-1:0]    wk;
  logic [NUMW-1:0]  num_nxt [3];
  logic [PRODW-1:0] prod    [3];
  logic [NUMW-1:0]  fq      [3];
  logic [NUMW-1:0]  rem     [3];
  logic [CH_W-1:0]  q       [3];

  logic             v2_r, v3_r, out_valid_r;
  logic [PIX_W-1:0] idx2_r, idx3_r;
  logic [NUMW-1:0]  num2_r [3];
  logic [NUMW-1:0]  num3_r [3];
  logic [CH_W-1:0]  q0_r   [3];
  res_t             res_r;

  // whole pipeline advances together; stall only when the result is not taken
  assign en        = !out_valid_r || out_ready;
  assign pipe_busy = v2_r || v3_r;
  assign wk        = KB'(FADE_STEPS) - k;

  always_comb begin
    // an entry never written reads as zero
    t_col = rd.tgt_ok ? tgt_rdata : '0;
    s_col = rd.shw_ok ? shw_rdata : '0;
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = NUMW'(t_col[c*CH_W +: CH_W]) * NUMW'(wk)
                 + NUMW'(s_col[c*CH_W +: CH_W]) * NUMW'(k);
      // reciprocal estimate, low by at most one
      prod[c] = PRODW'(num2_r[c]) * PRODW'(RECIP);
      // correct the estimate against the remainder
      fq[c]  = NUMW'(q0_r[c]) * NUMW'(FADE_STEPS);
      rem[c] = num3_r[c] - fq[c];
      q[c]   = (rem[c] >= NUMW'(FADE_STEPS)) ? q0_r[c] + CH_W'(1) : q0_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v2_r        <= rd.vld;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx2_r <= rd.idx;
      idx3_r <= idx2_r;
      for (int c = 0; c < 3; c++) begin
        num2_r[c] <= num_nxt[c];
        num3_r[c] <= num2_r[c];
        q0_r[c]   <= prod[c][NUMW +: CH_W];
      end
      res_r.pixel <= idx3_r;
      res_r.red   <= q[2];
      res_r.green <= q[1];
      res_r.blue  <= q[0];
      res_r.last  <= (idx3_r == PIX_W'(NUM_PIXELS - 1));
    end
  end

  assign wb.vld    = en && v3_r;
  assign wb.idx    = idx3_r;
  assign wb_data   = {q[2], q[1], q[0]};
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

>>> hw/rtl/led_strip_crossfade_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// in_chan   in   valid/ready          func, pixel, red, green, blue
// out_chan  out  valid/ready          pixel, red, green, blue, last
//
// Set-target and start requests finish on being accepted. An active tick
// moves one pixel per cycle, while the output is not stalled, through the
// target and shown-color memory read ports, then a three-stage blend pipeline drains.
// Synchronous active-low reset; colors read as zero until written.
// Output stall freezes the whole blend pipeline; the next request is taken
// while the final result of a tick still waits in the output register.

module led_strip_crossfade_top import lsc_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF,
  parameter int FADE_STEPS = FADE_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lsc_in_if.sink     in_chan,
  lsc_out_if.source  out_chan
);

  localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int KB = $clog2(FADE_STEPS + 1);

  logic             en;
  logic             pipe_busy;
  logic             tgt_we;
  logic [AW-1:0]    rd_addr;
  rd_t              rd;
  wb_t              wb;
  logic [KB-1:0]    k;
  logic [COL_W-1:0] tgt_rdata;
  logic [COL_W-1:0] shw_rdata;
  logic [COL_W-1:0] wb_data;
  res_t             res;

  lsc_ctrl #(
    .NUM_PIXELS (NUM_PIXELS),
    .FADE_STEPS (FADE_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_func   (in_chan.func),
    .in_pixel  (in_chan.pixel),
    .en        (en),
    .pipe_busy (pipe_busy),
    .wb        (wb),
    .tgt_we    (tgt_we),
    .rd_addr   (rd_addr),
    .rd        (rd),
    .k         (k)
  );

  lsc_ram #(
    .WIDTH (COL_W),
    .DEPTH (NUM_PIXELS)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (in_chan.pixel[AW-1:0]),
    .wdata ({in_chan.red, in_chan.green, in_chan.blue}),
    .re    (en),
    .raddr (rd_addr),
    .rdata (tgt_rdata)
  );

  lsc_ram #(
    .WIDTH (COL_W),
    .DEPTH (NUM_PIXELS)
  ) u_shw_ram (
    .clk   (clk),
    .we    (wb.vld),
    .waddr (wb.idx[AW-1:0]),
    .wdata (wb_data),
    .re    (en),
    .raddr (rd_addr),
    .rdata (shw_rdata)
  );

  lsc_blend #(
    .NUM_PIXELS (NUM_PIXELS),
    .FADE_STEPS (FADE_STEPS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (rd),
    .tgt_rdata (tgt_rdata),
    .shw_rdata (shw_rdata),
    .k         (k),
    .en        (en),
    .pipe_busy (pipe_busy),
    .wb        (wb),
    .wb_data   (wb_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .res       (res)
  );

  assign out_chan.pixel = res.pixel;
  assign out_chan.red   = res.red;
  assign out_chan.green = res.green;
  assign out_chan.blue  = res.blue;
  assign out_chan.last  = res.last;

endmodule

>>> hw/rtl/lsc_checker.sv
`timescale 1ns / 1ps

module lsc_props import lsc_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PIX_W-1:0]  out_pixel,
  input logic [CH_W-1:0]   out_red,
  input logic [CH_W-1:0]   out_green,
  input logic [CH_W-1:0]   out_blue,
  input logic              out_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_last))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown out of reset");

  a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_pixel == PIX_W'(NUM_PIXELS - 1))))
    else $error("last flag does not match final pixel");

  // mid-run, further pixels are still owed, so no new request is taken
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken in the middle of a tick");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func != FN_TICK) && !out_valid |=> !out_valid)
    else $error("result from a request that emits none");

endmodule

bind led_strip_crossfade_top lsc_props #(
  .NUM_PIXELS (NUM_PIXELS)
) u_lsc_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_func   (in_chan.func),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_pixel (out_chan.pixel),
  .out_red   (out_chan.red),
  .out_green (out_chan.green),
  .out_blue  (out_chan.blue),
  .out_last  (out_chan.last)
);
